FILE: hw/rtl/ssbg_pkg.sv
// Shared types, constants and register codes for the spectral subtraction gain stage.
package ssbg_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int NUM_BINS_DEF = 256;
  localparam int BIN_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MAG_FRAC     = 7;
  localparam int SUM_W        = 2 * SAMPLE_BITS;
  localparam int ROOT_W       = SAMPLE_BITS + MAG_FRAC;
  localparam int MAG_W        = 32;
  localparam int EST_W        = 32;
  localparam int GAIN_W       = 32;
  localparam int CLEAN_W      = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVER_SUB = 2'd0,
    REG_FLOOR    = 2'd1,
    REG_SMOOTH   = 2'd2,
    REG_THRESH   = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] RESET_OVER_SUB = 16'd12288;
  localparam logic [CFG_DATA_W-1:0] RESET_FLOOR    = 16'd6554;
  localparam logic [CFG_DATA_W-1:0] RESET_SMOOTH   = 16'd62259;
  localparam logic [CFG_DATA_W-1:0] RESET_THRESH   = 16'd8192;

  typedef struct packed {
    logic [BIN_W-1:0]              bin_index;
    logic signed [SAMPLE_BITS-1:0] bin_real;
    logic signed [SAMPLE_BITS-1:0] bin_imag;
  } bin_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]              out_bin;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
  } bin_out_t;

  // What travels alongside the arithmetic: bin number, magnitudes and signs of the parts.
  typedef struct packed {
    logic [BIN_W-1:0]       bin_index;
    logic [SAMPLE_BITS-1:0] abs_re;
    logic [SAMPLE_BITS-1:0] abs_im;
    logic                   neg_re;
    logic                   neg_im;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic zero;
    logic sat;
  } div_tag_t;

endpackage

FILE: hw/rtl/ssbg_ram.sv
// Generic single-port-write, registered-read RAM.
module ssbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ssbg_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side word carried along.
module ssbg_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ssbg_pkg::SUM_W-1:0]   radicand,
  input  ssbg_pkg::ctx_t               in_ctx,
  output logic                         out_valid,
  output logic [ssbg_pkg::ROOT_W-1:0]  root,
  output ssbg_pkg::ctx_t               out_ctx
);

  localparam int RootW = ssbg_pkg::ROOT_W;
  localparam int RemW  = RootW + 2;
  localparam int XW    = 2 * RootW;

  logic                 vld_q  [RootW];
  logic [RemW-1:0]      rem_q  [RootW];
  logic [RootW-1:0]     root_q [RootW];
  logic [XW-1:0]        x_q    [RootW];
  ssbg_pkg::ctx_t       ctx_q  [RootW];

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    logic             vld_i;
    logic [RemW-1:0]  rem_i;
    logic [RootW-1:0] root_i;
    logic [XW-1:0]    x_i;
    ssbg_pkg::ctx_t   ctx_i;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;

    if (j == 0) begin : g_first
      // The radicand is scaled by 2^14 so that the root comes out in Q.7.
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = {radicand, {(2 * ssbg_pkg::MAG_FRAC){1'b0}}};
      assign ctx_i  = in_ctx;
    end else begin : g_next
      assign vld_i  = vld_q[j-1];
      assign rem_i  = rem_q[j-1];
      assign root_i = root_q[j-1];
      assign x_i    = x_q[j-1];
      assign ctx_i  = ctx_q[j-1];
    end

    assign rem_sh = {rem_i[RemW-3:0], x_i[XW-1 -: 2]};
    assign trial  = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_i[RootW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_i[RootW-2:0], 1'b0};
        end
        x_q[j]   <= {x_i[XW-3:0], 2'b00};
        ctx_q[j] <= ctx_i;
      end
    end
  end

  assign out_valid = vld_q[RootW-1];
  assign root      = root_q[RootW-1];
  assign out_ctx   = ctx_q[RootW-1];

endmodule

FILE: hw/rtl/ssbg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side word carried along.
module ssbg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ssbg_pkg::GAIN_W-1:0]  rem_init,
  input  logic [ssbg_pkg::GAIN_W-1:0]  dividend_lo,
  input  logic [ssbg_pkg::MAG_W-1:0]   divisor,
  input  ssbg_pkg::div_tag_t           in_tag,
  output logic                         out_valid,
  output logic [ssbg_pkg::GAIN_W-1:0]  quotient,
  output ssbg_pkg::div_tag_t           out_tag
);

  localparam int QW = ssbg_pkg::GAIN_W;
  localparam int DW = ssbg_pkg::MAG_W;

  logic               vld_q [QW];
  logic [DW-1:0]      rem_q [QW];
  logic [QW-1:0]      lo_q  [QW];
  logic [QW-1:0]      q_q   [QW];
  logic [DW-1:0]      dv_q  [QW];
  ssbg_pkg::div_tag_t tag_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic               vld_i;
    logic [DW-1:0]      rem_i;
    logic [QW-1:0]      lo_i;
    logic [QW-1:0]      q_i;
    logic [DW-1:0]      dv_i;
    ssbg_pkg::div_tag_t tag_i;
    logic [DW:0]        rem_sh;

    if (j == 0) begin : g_first
      assign vld_i = in_valid;
      assign rem_i = rem_init;
      assign lo_i  = dividend_lo;
      assign q_i   = '0;
      assign dv_i  = divisor;
      assign tag_i = in_tag;
    end else begin : g_next
      assign vld_i = vld_q[j-1];
      assign rem_i = rem_q[j-1];
      assign lo_i  = lo_q[j-1];
      assign q_i   = q_q[j-1];
      assign dv_i  = dv_q[j-1];
      assign tag_i = tag_q[j-1];
    end

    assign rem_sh = {rem_i, lo_i[QW-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= {1'b0, dv_i}) begin
          rem_q[j] <= DW'(rem_sh - {1'b0, dv_i});
          q_q[j]   <= {q_i[QW-2:0], 1'b1};
        end else begin
          rem_q[j] <= rem_sh[DW-1:0];
          q_q[j]   <= {q_i[QW-2:0], 1'b0};
        end
        lo_q[j]  <= {lo_i[QW-2:0], 1'b0};
        dv_q[j]  <= dv_i;
        tag_q[j] <= tag_i;
      end
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quotient  = q_q[QW-1];
  assign out_tag   = tag_q[QW-1];

endmodule

FILE: hw/rtl/spectral_subtraction_bin_gain.sv
// Spectral subtraction gain stage: per-bin noise tracking and gain scaling of FFT bins.
// Throughput: one bin word per cycle while the output is not stalled; a bin whose slot
// matches one of the two words ahead of it waits for the noise estimate read-modify-write
// to complete. Reset: registers return to defaults and a clearing pass zeroes the noise
// store, during which no bin word is accepted.
module spectral_subtraction_bin_gain #(
  parameter int NUM_BINS = ssbg_pkg::NUM_BINS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             bin_valid,
  output logic                             bin_stall,
  input  ssbg_pkg::bin_in_t                bin_data,
  output logic                             scaled_valid,
  input  logic                             scaled_stall,
  output ssbg_pkg::bin_out_t               scaled_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssbg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssbg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW    = $clog2(NUM_BINS);
  localparam int SB    = ssbg_pkg::SAMPLE_BITS;
  localparam int SqW   = 2 * SB;
  localparam int PW    = SB + ssbg_pkg::GAIN_W;
  localparam int RW    = PW + 1 - 16;
  localparam int EW    = ssbg_pkg::EST_W;
  localparam int MW    = ssbg_pkg::MAG_W;
  localparam int CW    = ssbg_pkg::CLEAN_W;
  localparam int BinN  = 1 << ssbg_pkg::BIN_W;

  // ---------------- configuration ----------------
  logic [15:0] over_sub, floor_fac, smooth, thresh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      over_sub  <= ssbg_pkg::RESET_OVER_SUB;
      floor_fac <= ssbg_pkg::RESET_FLOOR;
      smooth    <= ssbg_pkg::RESET_SMOOTH;
      thresh    <= ssbg_pkg::RESET_THRESH;
    end else if (cfg_valid) begin
      case (ssbg_pkg::cfg_reg_t'(cfg_index))
        ssbg_pkg::REG_OVER_SUB: over_sub  <= cfg_data;
        ssbg_pkg::REG_FLOOR:    floor_fac <= cfg_data;
        ssbg_pkg::REG_SMOOTH:   smooth    <= cfg_data;
        ssbg_pkg::REG_THRESH:   thresh    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass ----------------
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(NUM_BINS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // ---------------- flow control ----------------
  logic en, en_up, hazard;

  assign en        = !scaled_valid || !scaled_stall;
  assign en_up     = en && !hazard;
  assign bin_stall = !en_up || clr_busy;

  // ---------------- front end: magnitudes and squares ----------------
  ssbg_pkg::ctx_t in_ctx;
  logic           s0_valid, s1_valid, s2_valid;
  ssbg_pkg::ctx_t s0_ctx, s1_ctx, s2_ctx;
  logic [SqW-1:0] s1_sq_re, s1_sq_im;
  logic [ssbg_pkg::SUM_W-1:0] s2_sum;

  always_comb begin
    in_ctx.bin_index = bin_data.bin_index;
    in_ctx.neg_re    = bin_data.bin_real[SB-1];
    in_ctx.neg_im    = bin_data.bin_imag[SB-1];
    in_ctx.abs_re    = in_ctx.neg_re ? (~bin_data.bin_real + 1'b1) : bin_data.bin_real;
    in_ctx.abs_im    = in_ctx.neg_im ? (~bin_data.bin_imag + 1'b1) : bin_data.bin_imag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en_up) begin
      s0_valid <= bin_valid && !clr_busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      s0_ctx   <= in_ctx;
      s1_ctx   <= s0_ctx;
      s1_sq_re <= SqW'(s0_ctx.abs_re) * SqW'(s0_ctx.abs_re);
      s1_sq_im <= SqW'(s0_ctx.abs_im) * SqW'(s0_ctx.abs_im);
      s2_ctx   <= s1_ctx;
      s2_sum   <= s1_sq_re + s1_sq_im;
    end
  end

  // ---------------- magnitude ----------------
  logic                        a_valid;
  logic [ssbg_pkg::ROOT_W-1:0] a_root;
  ssbg_pkg::ctx_t              a_ctx;

  ssbg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en_up),
    .in_valid  (s2_valid),
    .radicand  (s2_sum),
    .in_ctx    (s2_ctx),
    .out_valid (a_valid),
    .root      (a_root),
    .out_ctx   (a_ctx)
  );

  // Bin number to store slot, worked out at elaboration.
  logic [AW-1:0] slot_lut [BinN];

  for (genvar i = 0; i < BinN; i++) begin : g_slot
    localparam int unsigned SlotVal = i % NUM_BINS;
    assign slot_lut[i] = AW'(SlotVal);
  end

  logic [AW-1:0] a_slot;
  logic [MW-1:0] a_mag;

  assign a_slot = slot_lut[a_ctx.bin_index];
  assign a_mag  = MW'(a_root);

  // ---------------- noise estimate read-modify-write ----------------
  logic           b_valid, c_valid;
  logic [AW-1:0]  b_slot, c_slot;
  logic [MW-1:0]  b_mag, c_mag;
  ssbg_pkg::ctx_t b_ctx, c_ctx;
  logic [EW-1:0]  b_est, c_est;
  logic [47:0]    c_p_thr, c_p_old;
  logic [48:0]    c_p_new;
  logic [16:0]    w_new;

  // An item may not read its slot while an earlier one is still updating it.
  assign hazard = a_valid && ((b_valid && (b_slot == a_slot)) ||
                              (c_valid && (c_slot == a_slot)));

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, est_new;

  assign ram_we    = clr_busy || c_valid;
  assign ram_waddr = clr_busy ? clr_addr : c_slot;
  assign ram_wdata = clr_busy ? '0 : est_new;

  ssbg_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BINS)
  ) u_noise_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (a_slot),
    .rdata (b_est)
  );

  assign w_new = 17'h10000 - {1'b0, smooth};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid && !hazard;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_slot  <= a_slot;
      b_mag   <= a_mag;
      b_ctx   <= a_ctx;
      c_slot  <= b_slot;
      c_mag   <= b_mag;
      c_ctx   <= b_ctx;
      c_est   <= b_est;
      c_p_thr <= 48'(b_est) * 48'(thresh);
      c_p_old <= 48'(b_est) * 48'(smooth);
      c_p_new <= 49'(b_mag) * 49'(w_new);
    end
  end

  logic [49:0] c_sm_sum;
  logic [33:0] c_sm;
  logic [EW-1:0] c_sm_sat;
  logic        c_active;

  assign c_sm_sum = 50'(c_p_old) + 50'(c_p_new) + 50'(32768);
  assign c_sm     = c_sm_sum[49:16];
  assign c_sm_sat = (c_sm[33:32] != 2'b00) ? '1 : c_sm[31:0];
  assign c_active = 48'({c_mag, 12'b0}) < c_p_thr;

  // A cleared estimate starts from the current magnitude.
  assign est_new = (c_est == '0) ? c_mag : (c_active ? c_sm_sat : c_est);

  // ---------------- cleaned magnitude ----------------
  logic           d_valid, e_valid, f_valid;
  ssbg_pkg::ctx_t d_ctx, e_ctx, f_ctx;
  logic [MW-1:0]  d_mag, e_mag, f_mag;
  logic [EW-1:0]  d_est;
  logic [47:0]    e_p_os, e_p_ff;
  logic [CW-1:0]  f_clean;

  logic signed [53:0] e_diff, e_floor;
  logic [CW-1:0]      e_clean;

  assign e_diff  = $signed({6'b0, e_mag, 16'b0}) - $signed({2'b0, e_p_os, 4'b0});
  assign e_floor = $signed({6'b0, e_p_ff});
  assign e_clean = (e_diff < e_floor) ? e_p_ff : e_diff[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ctx   <= c_ctx;
      d_mag   <= c_mag;
      d_est   <= est_new;
      e_ctx   <= d_ctx;
      e_mag   <= d_mag;
      e_p_os  <= 48'(d_est) * 48'(over_sub);
      e_p_ff  <= 48'(d_est) * 48'(floor_fac);
      f_ctx   <= e_ctx;
      f_mag   <= e_mag;
      f_clean <= e_clean;
    end
  end

  // ---------------- gain ----------------
  ssbg_pkg::div_tag_t f_tag, g_tag;
  logic               g_valid;
  logic [ssbg_pkg::GAIN_W-1:0] g_quot, gain;

  always_comb begin
    f_tag.ctx  = f_ctx;
    f_tag.zero = (f_mag == '0);
    // The quotient cannot fit in 32 bits when the upper part already reaches the divisor.
    f_tag.sat  = {16'b0, f_clean[CW-1:32]} >= f_mag;
  end

  ssbg_div u_div (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (f_valid),
    .rem_init    (32'(f_clean[CW-1:32])),
    .dividend_lo (f_clean[31:0]),
    .divisor     (f_mag),
    .in_tag      (f_tag),
    .out_valid   (g_valid),
    .quotient    (g_quot),
    .out_tag     (g_tag)
  );

  assign gain = g_tag.zero ? '0 : (g_tag.sat ? '1 : g_quot);

  // ---------------- scaling ----------------
  logic           h_valid;
  ssbg_pkg::ctx_t h_ctx;
  logic [PW-1:0]  h_prod_re, h_prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_ctx     <= g_tag.ctx;
      h_prod_re <= PW'(g_tag.ctx.abs_re) * PW'(gain);
      h_prod_im <= PW'(g_tag.ctx.abs_im) * PW'(gain);
    end
  end

  function automatic logic [SB-1:0] round_sat(input logic [PW-1:0] prod, input logic neg);
    logic [PW:0]   sum;
    logic [RW-1:0] p;
    logic [RW-1:0] lim;
    begin
      sum = (PW + 1)'(prod) + (PW + 1)'(32768);
      p   = sum[PW:16];
      if (neg) begin
        lim = RW'(1) << (SB - 1);
        if (p > lim) begin
          p = lim;
        end
        round_sat = ~p[SB-1:0] + 1'b1;
      end else begin
        lim = (RW'(1) << (SB - 1)) - 1'b1;
        if (p > lim) begin
          p = lim;
        end
        round_sat = p[SB-1:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
    end else if (en) begin
      scaled_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scaled_data.out_bin  <= h_ctx.bin_index;
      scaled_data.out_real <= round_sat(h_prod_re, h_ctx.neg_re);
      scaled_data.out_imag <= round_sat(h_prod_im, h_ctx.neg_im);
    end
  end

endmodule
